// File: sv/imu_pfa_pkg.sv
package imu_pfa_pkg;

	// Field widths
	localparam int SEC_W  = 31;
	localparam int NSEC_W = 30;
	localparam int OFF_W  = 41;
	localparam int VAL_W  = 32;
	localparam int PROD_W = 64;

	// APB port geometry: registers sit at 8*i, 64-bit data
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Time constants
	localparam longint NS_PER_SEC = 64'd1000000000;
	localparam longint SEC_MAX    = 64'd2147483647;

	// Biased remainder: nsec + offset + DIV_BIAS * 1e9 is always positive and below 2^42
	localparam int     DIV_W     = 42;
	localparam int     DIV_BIAS  = 1100;
	localparam int     DIV_HI_LO = 21;
	localparam int     DIV_HI_W  = DIV_W - DIV_HI_LO;
	localparam int     RECIP_W   = 24;
	localparam int     QPROD_W   = DIV_HI_W + RECIP_W;
	localparam int     QE_W      = 12;
	localparam int     QE_SHIFT  = 53 - DIV_HI_LO;
	// floor(2^53 / 1e9)
	localparam logic [RECIP_W-1:0] RECIP = 24'd9007199;
	localparam logic [DIV_W-1:0] BIAS_NS = DIV_W'(longint'(DIV_BIAS) * NS_PER_SEC);
	localparam int     REM_W     = 31;
	localparam int     OSEC_W    = SEC_W + 3;

	// Q1.30 unit
	localparam logic signed [VAL_W-1:0] Q30_ONE = 32'sd1073741824;
	localparam logic signed [VAL_W-1:0] Q30_NEG = -32'sd1073741824;

	typedef enum logic [2:0] {
		REG_TIME_OFFSET   = 3'd0,
		REG_ROTATE_ENABLE = 3'd1,
		REG_COS_PITCH     = 3'd2,
		REG_SIN_PITCH     = 3'd3,
		REG_COS_HALF      = 3'd4,
		REG_SIN_HALF      = 3'd5
	} reg_idx_t;

	// Configuration as seen by the datapath; trig values already clamped to +-1.0
	typedef struct packed {
		logic signed [OFF_W-1:0] time_offset_ns;
		logic                    rotate_enable;
		logic signed [VAL_W-1:0] cos_pitch;
		logic signed [VAL_W-1:0] sin_pitch;
		logic signed [VAL_W-1:0] cos_half_pitch;
		logic signed [VAL_W-1:0] sin_half_pitch;
	} cfg_t;

	// Clamp a Q1.30 register value to [-1.0, 1.0]
	function automatic logic signed [VAL_W-1:0] clamp_q30(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		r = v;
		if (v > Q30_ONE)
			r = Q30_ONE;
		else if (v < Q30_NEG)
			r = Q30_NEG;
		return r;
	endfunction

	// Add or subtract two Q1.30 products, round half up, saturate to [lo, hi]
	function automatic logic signed [VAL_W-1:0] rnd_sat(
		input logic signed [PROD_W-1:0] a,
		input logic signed [PROD_W-1:0] b,
		input logic                     sub,
		input logic signed [PROD_W-1:0] lo,
		input logic signed [PROD_W-1:0] hi
	);
		logic signed [PROD_W-1:0] sum;
		logic signed [PROD_W-1:0] r;
		logic signed [VAL_W-1:0]  res;
		sum = sub ? (a - b) : (a + b);
		r = (sum + 64'sd536870912) >>> 30;
		if (r > hi)
			res = VAL_W'(hi);
		else if (r < lo)
			res = VAL_W'(lo);
		else
			res = VAL_W'(r);
		return res;
	endfunction

endpackage

// File: sv/imu_pfa_regs.sv
module imu_pfa_regs
	import imu_pfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic signed [OFF_W-1:0] offset_q;
	logic                    rot_q;
	logic signed [VAL_W-1:0] cos_q;
	logic signed [VAL_W-1:0] sin_q;
	logic signed [VAL_W-1:0] chalf_q;
	logic signed [VAL_W-1:0] shalf_q;
	logic                    wr_en;
	reg_idx_t                idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			rot_q    <= 1'b0;
			cos_q    <= Q30_ONE;
			sin_q    <= '0;
			chalf_q  <= Q30_ONE;
			shalf_q  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_TIME_OFFSET:   offset_q <= pwdata[OFF_W-1:0];
				REG_ROTATE_ENABLE: rot_q    <= pwdata[0];
				REG_COS_PITCH:     cos_q    <= pwdata[VAL_W-1:0];
				REG_SIN_PITCH:     sin_q    <= pwdata[VAL_W-1:0];
				REG_COS_HALF:      chalf_q  <= pwdata[VAL_W-1:0];
				REG_SIN_HALF:      shalf_q  <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register values, sign extended
	always_comb begin
		unique case (idx)
			REG_TIME_OFFSET:   prdata = DATA_W'(offset_q);
			REG_ROTATE_ENABLE: prdata = {{(DATA_W-1){1'b0}}, rot_q};
			REG_COS_PITCH:     prdata = DATA_W'(cos_q);
			REG_SIN_PITCH:     prdata = DATA_W'(sin_q);
			REG_COS_HALF:      prdata = DATA_W'(chalf_q);
			REG_SIN_HALF:      prdata = DATA_W'(shalf_q);
			default:           prdata = '0;
		endcase
	end

	// Hand the datapath clamped trig values
	always_comb begin
		cfg.time_offset_ns = offset_q;
		cfg.rotate_enable  = rot_q;
		cfg.cos_pitch      = clamp_q30(cos_q);
		cfg.sin_pitch      = clamp_q30(sin_q);
		cfg.cos_half_pitch = clamp_q30(chalf_q);
		cfg.sin_half_pitch = clamp_q30(shalf_q);
	end

endmodule

// File: sv/imu_pfa_time.sv
module imu_pfa_time
	import imu_pfa_pkg::*;
(
	input  logic              clk,
	input  cfg_t              cfg,
	input  logic [SEC_W-1:0]  sec_s1,
	input  logic [NSEC_W-1:0] nsec_s1,
	output logic [SEC_W-1:0]  sec_s4,
	output logic [NSEC_W-1:0] nsec_s4
);

	logic signed [OFF_W-1:0] off_eff;
	logic [DIV_W-1:0]        rb;
	logic [QPROD_W-1:0]      qprod;
	logic [DIV_W-1:0]        rb_s2;
	logic [QE_W-1:0]         qe_s2;
	logic [SEC_W-1:0]        sec_s2;
	logic [DIV_W-1:0]        qm;
	logic [DIV_W-1:0]        rem_full;
	logic [REM_W-1:0]        rem_s3;
	logic [QE_W-1:0]         qe_s3;
	logic [SEC_W-1:0]        sec_s3;
	logic                    carry;
	logic [REM_W-1:0]        rem_fix;
	logic [QE_W:0]           q_fix;
	logic signed [OSEC_W-1:0] osec;

	// Drop offsets of one nanosecond or less; bias the sub-second part positive
	always_comb begin
		if (cfg.time_offset_ns == 41'sd0 || cfg.time_offset_ns == 41'sd1 ||
		    cfg.time_offset_ns == -41'sd1)
			off_eff = '0;
		else
			off_eff = cfg.time_offset_ns;
		rb = DIV_W'(nsec_s1) + {{(DIV_W-OFF_W){off_eff[OFF_W-1]}}, off_eff} + BIAS_NS;
		qprod = QPROD_W'(rb[DIV_W-1:DIV_HI_LO]) * QPROD_W'(RECIP);
	end

	// Quotient estimate, low by at most one
	always_ff @(posedge clk) begin
		rb_s2  <= rb;
		qe_s2  <= qprod[QE_SHIFT+QE_W-1:QE_SHIFT];
		sec_s2 <= sec_s1;
	end

	// Remainder of the estimate, below twice one second
	always_comb begin
		qm       = DIV_W'(qe_s2) * DIV_W'(NS_PER_SEC);
		rem_full = rb_s2 - qm;
	end

	always_ff @(posedge clk) begin
		rem_s3 <= rem_full[REM_W-1:0];
		qe_s3  <= qe_s2;
		sec_s3 <= sec_s2;
	end

	// Correct the quotient, remove the bias and saturate
	always_comb begin
		carry   = rem_s3 >= REM_W'(NS_PER_SEC);
		rem_fix = carry ? (rem_s3 - REM_W'(NS_PER_SEC)) : rem_s3;
		q_fix   = (QE_W+1)'(qe_s3) + (QE_W+1)'(carry);
		osec    = $signed(OSEC_W'(sec_s3)) + $signed(OSEC_W'(q_fix)) -
		          $signed(OSEC_W'(DIV_BIAS));
	end

	always_ff @(posedge clk) begin
		if (osec[OSEC_W-1]) begin
			sec_s4  <= '0;
			nsec_s4 <= '0;
		end else if (osec > $signed(OSEC_W'(SEC_MAX))) begin
			sec_s4  <= SEC_W'(SEC_MAX);
			nsec_s4 <= NSEC_W'(NS_PER_SEC - 64'd1);
		end else begin
			sec_s4  <= osec[SEC_W-1:0];
			nsec_s4 <= rem_fix[NSEC_W-1:0];
		end
	end

endmodule

// File: sv/imu_pfa_rot.sv
module imu_pfa_rot
	import imu_pfa_pkg::*;
(
	input  logic                    clk,
	input  cfg_t                    cfg,
	input  logic signed [VAL_W-1:0] gx_s1,
	input  logic signed [VAL_W-1:0] gy_s1,
	input  logic signed [VAL_W-1:0] gz_s1,
	input  logic signed [VAL_W-1:0] ax_s1,
	input  logic signed [VAL_W-1:0] ay_s1,
	input  logic signed [VAL_W-1:0] az_s1,
	input  logic signed [VAL_W-1:0] qw_s1,
	input  logic signed [VAL_W-1:0] qx_s1,
	input  logic signed [VAL_W-1:0] qy_s1,
	input  logic signed [VAL_W-1:0] qz_s1,
	output logic signed [VAL_W-1:0] gx_s4,
	output logic signed [VAL_W-1:0] gy_s4,
	output logic signed [VAL_W-1:0] gz_s4,
	output logic signed [VAL_W-1:0] ax_s4,
	output logic signed [VAL_W-1:0] ay_s4,
	output logic signed [VAL_W-1:0] az_s4,
	output logic signed [VAL_W-1:0] qw_s4,
	output logic signed [VAL_W-1:0] qx_s4,
	output logic signed [VAL_W-1:0] qy_s4,
	output logic signed [VAL_W-1:0] qz_s4
);

	localparam logic signed [PROD_W-1:0] V_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] V_MIN = -64'sd2147483648;
	localparam logic signed [PROD_W-1:0] Q_MAX = 64'sd1073741824;
	localparam logic signed [PROD_W-1:0] Q_MIN = -64'sd1073741824;

	logic signed [PROD_W-1:0] c, s, ch, sh;
	// Vector products: c*x, s*z, c*z, s*x for gyro and accel
	logic signed [PROD_W-1:0] g_cx_s2, g_sz_s2, g_cz_s2, g_sx_s2;
	logic signed [PROD_W-1:0] a_cx_s2, a_sz_s2, a_cz_s2, a_sx_s2;
	// Quaternion products with the half-angle terms
	logic signed [PROD_W-1:0] chw_s2, shy_s2, chx_s2, shz_s2;
	logic signed [PROD_W-1:0] chy_s2, shw_s2, chz_s2, shx_s2;
	logic signed [VAL_W-1:0]  gx_s2, gy_s2, gz_s2, ax_s2, ay_s2, az_s2;
	logic signed [VAL_W-1:0]  qw_s2, qx_s2, qy_s2, qz_s2;
	logic signed [VAL_W-1:0]  gx_s3, gy_s3, gz_s3, ax_s3, ay_s3, az_s3;
	logic signed [VAL_W-1:0]  qw_s3, qx_s3, qy_s3, qz_s3;

	assign c  = PROD_W'($signed(cfg.cos_pitch));
	assign s  = PROD_W'($signed(cfg.sin_pitch));
	assign ch = PROD_W'($signed(cfg.cos_half_pitch));
	assign sh = PROD_W'($signed(cfg.sin_half_pitch));

	// Register all products, carry raw values for pass-through
	always_ff @(posedge clk) begin
		g_cx_s2 <= c * PROD_W'(gx_s1);
		g_sz_s2 <= s * PROD_W'(gz_s1);
		g_cz_s2 <= c * PROD_W'(gz_s1);
		g_sx_s2 <= s * PROD_W'(gx_s1);
		a_cx_s2 <= c * PROD_W'(ax_s1);
		a_sz_s2 <= s * PROD_W'(az_s1);
		a_cz_s2 <= c * PROD_W'(az_s1);
		a_sx_s2 <= s * PROD_W'(ax_s1);
		chw_s2  <= ch * PROD_W'(qw_s1);
		shy_s2  <= sh * PROD_W'(qy_s1);
		chx_s2  <= ch * PROD_W'(qx_s1);
		shz_s2  <= sh * PROD_W'(qz_s1);
		chy_s2  <= ch * PROD_W'(qy_s1);
		shw_s2  <= sh * PROD_W'(qw_s1);
		chz_s2  <= ch * PROD_W'(qz_s1);
		shx_s2  <= sh * PROD_W'(qx_s1);
		gx_s2 <= gx_s1;
		gy_s2 <= gy_s1;
		gz_s2 <= gz_s1;
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		az_s2 <= az_s1;
		qw_s2 <= qw_s1;
		qx_s2 <= qx_s1;
		qy_s2 <= qy_s1;
		qz_s2 <= qz_s1;
	end

	// Sum, round and saturate, or pass through when rotation is off; gyro and accel y always pass through
	always_ff @(posedge clk) begin
		gy_s3 <= gy_s2;
		ay_s3 <= ay_s2;
		if (cfg.rotate_enable) begin
			gx_s3 <= rnd_sat(g_cx_s2, g_sz_s2, 1'b0, V_MIN, V_MAX);
			gz_s3 <= rnd_sat(g_cz_s2, g_sx_s2, 1'b1, V_MIN, V_MAX);
			ax_s3 <= rnd_sat(a_cx_s2, a_sz_s2, 1'b0, V_MIN, V_MAX);
			az_s3 <= rnd_sat(a_cz_s2, a_sx_s2, 1'b1, V_MIN, V_MAX);
			qw_s3 <= rnd_sat(chw_s2, shy_s2, 1'b1, Q_MIN, Q_MAX);
			qx_s3 <= rnd_sat(chx_s2, shz_s2, 1'b0, Q_MIN, Q_MAX);
			qy_s3 <= rnd_sat(chy_s2, shw_s2, 1'b0, Q_MIN, Q_MAX);
			qz_s3 <= rnd_sat(chz_s2, shx_s2, 1'b1, Q_MIN, Q_MAX);
		end else begin
			gx_s3 <= gx_s2;
			gz_s3 <= gz_s2;
			ax_s3 <= ax_s2;
			az_s3 <= az_s2;
			qw_s3 <= qw_s2;
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
			qz_s3 <= qz_s2;
		end
	end

	// Align with the time path
	always_ff @(posedge clk) begin
		gx_s4 <= gx_s3;
		gy_s4 <= gy_s3;
		gz_s4 <= gz_s3;
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
		az_s4 <= az_s3;
		qw_s4 <= qw_s3;
		qx_s4 <= qx_s3;
		qy_s4 <= qy_s3;
		qz_s4 <= qz_s3;
	end

endmodule

// File: sv/imu_pitch_frame_alignment.sv
// IMU pitch frame alignment.
// Input channel: raise start with one IMU sample on the stamp, gyro, accel and
// quat ports; the item is taken at the clock edge where start is high and busy
// is low. busy is always low, so a sample can be given in every cycle.
// Result channel: done is high for one cycle with the aligned sample on the
// out_* ports; the item is taken at the end of that cycle.
// The result is registered; throughput is one item per cycle. The four register
// stages between the accepting edge and the result are: input register, product
// stage (pitch multipliers and the reciprocal multiply for the seconds
// quotient), sum/remainder stage, and correction/saturation stage.
// The receiver cannot stall: every result leaves in its own cycle.
// Configuration: APB registers at byte address 8*i (time_offset_ns,
// rotate_enable, cos_pitch, sin_pitch, cos_half_pitch, sin_half_pitch); write
// them only while no item is in flight.
// Reset clears the item pipeline and loads the register defaults (zero offset,
// rotation off, unit cosines, zero sines).
module imu_pitch_frame_alignment
	import imu_pfa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [SEC_W-1:0]        stamp_sec,
	input  logic [NSEC_W-1:0]       stamp_nsec,
	input  logic signed [VAL_W-1:0] gyro_x,
	input  logic signed [VAL_W-1:0] gyro_y,
	input  logic signed [VAL_W-1:0] gyro_z,
	input  logic signed [VAL_W-1:0] accel_x,
	input  logic signed [VAL_W-1:0] accel_y,
	input  logic signed [VAL_W-1:0] accel_z,
	input  logic signed [VAL_W-1:0] quat_w,
	input  logic signed [VAL_W-1:0] quat_x,
	input  logic signed [VAL_W-1:0] quat_y,
	input  logic signed [VAL_W-1:0] quat_z,
	output logic                    done,
	output logic [SEC_W-1:0]        out_sec,
	output logic [NSEC_W-1:0]       out_nsec,
	output logic signed [VAL_W-1:0] out_gyro_x,
	output logic signed [VAL_W-1:0] out_gyro_y,
	output logic signed [VAL_W-1:0] out_gyro_z,
	output logic signed [VAL_W-1:0] out_accel_x,
	output logic signed [VAL_W-1:0] out_accel_y,
	output logic signed [VAL_W-1:0] out_accel_z,
	output logic signed [VAL_W-1:0] out_quat_w,
	output logic signed [VAL_W-1:0] out_quat_x,
	output logic signed [VAL_W-1:0] out_quat_y,
	output logic signed [VAL_W-1:0] out_quat_z
);

	cfg_t                    cfg;
	logic                    accept;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [SEC_W-1:0]        sec_s1;
	logic [NSEC_W-1:0]       nsec_s1;
	logic signed [VAL_W-1:0] gx_s1, gy_s1, gz_s1, ax_s1, ay_s1, az_s1;
	logic signed [VAL_W-1:0] qw_s1, qx_s1, qy_s1, qz_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = v_s4;

	imu_pfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the item valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		sec_s1  <= stamp_sec;
		nsec_s1 <= stamp_nsec;
		gx_s1   <= gyro_x;
		gy_s1   <= gyro_y;
		gz_s1   <= gyro_z;
		ax_s1   <= accel_x;
		ay_s1   <= accel_y;
		az_s1   <= accel_z;
		qw_s1   <= quat_w;
		qx_s1   <= quat_x;
		qy_s1   <= quat_y;
		qz_s1   <= quat_z;
	end

	imu_pfa_time u_time (
		.clk     (clk),
		.cfg     (cfg),
		.sec_s1  (sec_s1),
		.nsec_s1 (nsec_s1),
		.sec_s4  (out_sec),
		.nsec_s4 (out_nsec)
	);

	imu_pfa_rot u_rot (
		.clk   (clk),
		.cfg   (cfg),
		.gx_s1 (gx_s1),
		.gy_s1 (gy_s1),
		.gz_s1 (gz_s1),
		.ax_s1 (ax_s1),
		.ay_s1 (ay_s1),
		.az_s1 (az_s1),
		.qw_s1 (qw_s1),
		.qx_s1 (qx_s1),
		.qy_s1 (qy_s1),
		.qz_s1 (qz_s1),
		.gx_s4 (out_gyro_x),
		.gy_s4 (out_gyro_y),
		.gz_s4 (out_gyro_z),
		.ax_s4 (out_accel_x),
		.ay_s4 (out_accel_y),
		.az_s4 (out_accel_z),
		.qw_s4 (out_quat_w),
		.qx_s4 (out_quat_x),
		.qy_s4 (out_quat_y),
		.qz_s4 (out_quat_z)
	);

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted item did not complete after four cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without an accepted item");

	a_nsec_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_nsec < NSEC_W'(NS_PER_SEC)))
		else $error("nanoseconds not normalized");

	a_gyro_y_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_gyro_y == $past(gyro_y, 4)))
		else $error("gyro y changed in flight");
`endif

endmodule
